### rtl/lss_pkg.sv
// Shared types and constants for the 3x3 Laplacian sharpening core.
// Holds pixel, window and column-select types plus register and operation codes.
// No dependencies; imported by the interfaces, the top level, lss_sharpen and lss_checker.
package lss_pkg;

	typedef logic [7:0] pix_t;

	// Window taps indexed [row][column]; row 0 is the top row, column 2 the newest.
	typedef pix_t [2:0][2:0] win_t;

	typedef struct packed {
		logic [1:0] lc;
		logic [1:0] mc;
		logic [1:0] rc;
	} sel_t;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_TOP    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_MID    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_BOTTOM = 3'd4;

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_FLUSH  = 1'b1;

	localparam logic [11:0] ROW_LENGTH_RST   = 12'd640;
	localparam logic [12:0] IMAGE_HEIGHT_RST = 13'd480;
	localparam logic [23:0] KERNEL_TOP_RST   = 24'd256;
	localparam logic [23:0] KERNEL_MID_RST   = 24'd130049;
	localparam logic [23:0] KERNEL_BOT_RST   = 24'd256;

endpackage

### rtl/lss_pix_in_if.sv
// Input stream channel of the sharpening core: valid, ready and one sample item.
// Depends on lss_pkg for the pixel type.
interface lss_pix_in_if;
	import lss_pkg::*;

	logic valid;
	logic ready;
	logic operation;
	pix_t sample;

	modport source (output valid, output operation, output sample, input ready);
	modport sink (input valid, input operation, input sample, output ready);

endinterface

### rtl/lss_pix_out_if.sv
// Output stream channel of the sharpening core: valid, ready and one result item.
// Depends on lss_pkg for the pixel type.
interface lss_pix_out_if;
	import lss_pkg::*;

	logic valid;
	logic ready;
	pix_t out_sample;
	logic last_in_run;
	logic end_of_frame;

	modport source (output valid, output out_sample, output last_in_run,
		output end_of_frame, input ready);
	modport sink (input valid, input out_sample, input last_in_run,
		input end_of_frame, output ready);

endinterface

### rtl/lss_cfg_if.sv
// Configuration write channel of the sharpening core: valid, ready, index, data.
// Depends on lss_pkg for the index and data widths.
interface lss_cfg_if;
	import lss_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);

endinterface

### rtl/laplacian_sharpen_3x3_core.sv
// Top level of the 3x3 Laplacian sharpening core with replicated borders.
// Depends on lss_pkg, the three channel interfaces, lss_ram and lss_sharpen.
//
// Usage: samples enter in raster order on pix_in (operation = sample), and each
// frame is closed by one row of flush items that replays the bottom border row.
// Results leave on pix_out one row and one column behind the input; the last
// item of a row gives two results, the second carrying the final column.
// last_in_run marks the final result of an input item and end_of_frame the
// last result of the frame. Registers are written on cfg (ready is always
// high); write them only while the block is idle, the block does not enforce it.
// A result passes through the read stage, the tap register and the output
// register after the transaction that completes its window. Items are taken
// one per clock while pix_out does not stall; an item giving two results holds
// the input until the single sharpening unit feeding the output has made both.
// The line stores are two block RAMs read at the current column on acceptance;
// a write to the column just read is forwarded. Reset clears counters, taps and
// valid flags at once; there is no clearing pass over the line stores.
// When pix_out stalls, the output register holds its result, one more item
// can still be taken into the read stage, then pix_in.ready drops.
module laplacian_sharpen_3x3_core #(
	parameter int MAX_ROW_SAMPLES = 2048,
	parameter int MAX_ROWS        = 4096
) (
	input  logic          clk,
	input  logic          arst_n,
	lss_cfg_if.sink       cfg,
	lss_pix_in_if.sink    pix_in,
	lss_pix_out_if.source pix_out
);
	import lss_pkg::*;

	localparam int CW = $clog2(MAX_ROW_SAMPLES);
	localparam int WW = $clog2(MAX_ROW_SAMPLES + 1);
	localparam int RW = $clog2(MAX_ROWS + 1);
	localparam int LW = (WW > 12) ? WW : 12;
	localparam int HW = (RW > 13) ? RW : 13;

	typedef struct packed {
		logic r_ge1;
		logic r_ge2;
		logic c_ge1;
		logic c_ge2;
		logic flush_row;
		logic last_col;
		logic bot_mid;
		logic fwd;
	} s1_ctl_t;

	logic [11:0] row_length_q;
	logic [12:0] image_height_q;
	logic [23:0] k_top_q;
	logic [23:0] k_mid_q;
	logic [23:0] k_bot_q;

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [LW-1:0] rl_x;
	logic [HW-1:0] ih_x;
	logic [WW-1:0] w_eff;
	logic [RW-1:0] h_eff;
	logic [CW-1:0] c_eff;
	logic [CW-1:0] c_next;
	logic [RW-1:0] r_eff;
	logic [RW-1:0] r_next;
	logic          flush_row;
	logic          last_col;
	s1_ctl_t       ctl_in;

	logic in_acc;
	logic s1_adv;
	logic s2_free;
	logic s2_emit;
	logic s2_last;
	logic out_free;

	logic          v_s1;
	s1_ctl_t       ctl_s1;
	logic [CW-1:0] col_s1;
	pix_t          sample_s1;
	pix_t          fwd_older_s1;
	pix_t          fwd_newer_s1;

	pix_t older_rd;
	pix_t newer_rd;
	pix_t older_cur;
	pix_t newer_cur;
	pix_t top_px;
	pix_t mid_px;
	pix_t bot_px;
	logic wr_en;

	win_t taps_q;
	win_t taps_next;

	logic       pend_a_s2;
	logic       pend_b_s2;
	logic       eof_s2;
	logic [1:0] a_lc_s2;
	logic [1:0] b_lc_s2;
	sel_t       sel;
	pix_t       sharp;

	logic out_valid_q;
	pix_t out_sample_q;
	logic out_last_q;
	logic out_eof_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_length_q   <= ROW_LENGTH_RST;
			image_height_q <= IMAGE_HEIGHT_RST;
			k_top_q        <= KERNEL_TOP_RST;
			k_mid_q        <= KERNEL_MID_RST;
			k_bot_q        <= KERNEL_BOT_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_ROW_LENGTH:    row_length_q   <= cfg.data[11:0];
				REG_IMAGE_HEIGHT:  image_height_q <= cfg.data[12:0];
				REG_KERNEL_TOP:    k_top_q        <= cfg.data;
				REG_KERNEL_MID:    k_mid_q        <= cfg.data;
				REG_KERNEL_BOTTOM: k_bot_q        <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		rl_x = LW'(row_length_q);
		ih_x = HW'(image_height_q);
		if (rl_x == '0) begin
			w_eff = WW'(1);
		end else if (rl_x > LW'(MAX_ROW_SAMPLES)) begin
			w_eff = WW'(MAX_ROW_SAMPLES);
		end else begin
			w_eff = WW'(rl_x);
		end
		if (ih_x == '0) begin
			h_eff = RW'(1);
		end else if (ih_x > HW'(MAX_ROWS)) begin
			h_eff = RW'(MAX_ROWS);
		end else begin
			h_eff = RW'(ih_x);
		end
		if (WW'(col_q) >= w_eff) begin
			c_eff = CW'(w_eff - WW'(1));
		end else begin
			c_eff = col_q;
		end
		if (row_q > h_eff) begin
			r_eff = h_eff;
		end else begin
			r_eff = row_q;
		end
		flush_row = (r_eff == h_eff);
		last_col  = ((WW'(c_eff) + WW'(1)) == w_eff);
		if (last_col) begin
			c_next = '0;
			r_next = flush_row ? '0 : r_eff + RW'(1);
		end else begin
			c_next = c_eff + CW'(1);
			r_next = r_eff;
		end
		ctl_in.r_ge1     = (r_eff != '0);
		ctl_in.r_ge2     = (r_eff > RW'(1));
		ctl_in.c_ge1     = (c_eff != '0);
		ctl_in.c_ge2     = (c_eff > CW'(1));
		ctl_in.flush_row = flush_row;
		ctl_in.last_col  = last_col;
		ctl_in.bot_mid   = (pix_in.operation == OP_FLUSH) || flush_row;
		ctl_in.fwd       = v_s1 && !ctl_s1.flush_row && (col_s1 == c_eff);
	end

	assign out_free     = !out_valid_q || pix_out.ready;
	assign s2_emit      = (pend_a_s2 || pend_b_s2) && out_free;
	assign s2_last      = s2_emit && !(pend_a_s2 && pend_b_s2);
	assign s2_free      = !(pend_a_s2 || pend_b_s2) || s2_last;
	assign s1_adv       = v_s1 && s2_free;
	assign pix_in.ready = !v_s1 || s1_adv;
	assign in_acc       = pix_in.valid && pix_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			v_s1  <= 1'b0;
		end else begin
			if (in_acc) begin
				col_q <= c_next;
				row_q <= r_next;
				v_s1  <= 1'b1;
			end else if (s1_adv) begin
				v_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			ctl_s1       <= ctl_in;
			col_s1       <= c_eff;
			sample_s1    <= pix_in.sample;
			fwd_older_s1 <= newer_cur;
			fwd_newer_s1 <= bot_px;
		end
	end

	assign older_cur = ctl_s1.fwd ? fwd_older_s1 : older_rd;
	assign newer_cur = ctl_s1.fwd ? fwd_newer_s1 : newer_rd;
	assign mid_px    = ctl_s1.r_ge1 ? newer_cur : 8'd0;
	assign top_px    = ctl_s1.r_ge2 ? older_cur : mid_px;
	assign bot_px    = ctl_s1.bot_mid ? mid_px : sample_s1;
	assign wr_en     = s1_adv && !ctl_s1.flush_row;

	lss_ram #(
		.WIDTH (8),
		.DEPTH (MAX_ROW_SAMPLES)
	) u_older_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (col_s1),
		.wdata (newer_cur),
		.re    (in_acc),
		.raddr (c_eff),
		.rdata (older_rd)
	);

	lss_ram #(
		.WIDTH (8),
		.DEPTH (MAX_ROW_SAMPLES)
	) u_newer_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (col_s1),
		.wdata (bot_px),
		.re    (in_acc),
		.raddr (c_eff),
		.rdata (newer_rd)
	);

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			taps_next[a][0] = taps_q[a][1];
			taps_next[a][1] = taps_q[a][2];
		end
		taps_next[0][2] = top_px;
		taps_next[1][2] = mid_px;
		taps_next[2][2] = bot_px;
	end

	// The taps only move when the result stage is free, so they double as its window.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taps_q    <= '0;
			pend_a_s2 <= 1'b0;
			pend_b_s2 <= 1'b0;
		end else if (s1_adv) begin
			taps_q    <= taps_next;
			pend_a_s2 <= ctl_s1.r_ge1 && ctl_s1.c_ge1;
			pend_b_s2 <= ctl_s1.r_ge1 && ctl_s1.last_col;
		end else if (s2_emit) begin
			if (pend_a_s2) begin
				pend_a_s2 <= 1'b0;
			end else begin
				pend_b_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			eof_s2  <= ctl_s1.flush_row && ctl_s1.last_col;
			a_lc_s2 <= ctl_s1.c_ge2 ? 2'd0 : 2'd1;
			b_lc_s2 <= ctl_s1.c_ge1 ? 2'd1 : 2'd2;
		end
	end

	always_comb begin
		if (pend_a_s2) begin
			sel = '{lc: a_lc_s2, mc: 2'd1, rc: 2'd2};
		end else begin
			sel = '{lc: b_lc_s2, mc: 2'd2, rc: 2'd2};
		end
	end

	lss_sharpen u_sharpen (
		.win    (taps_q),
		.k_top  (k_top_q),
		.k_mid  (k_mid_q),
		.k_bot  (k_bot_q),
		.sel    (sel),
		.result (sharp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s2_emit) begin
			out_valid_q <= 1'b1;
		end else if (pix_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_emit) begin
			out_sample_q <= sharp;
			out_last_q   <= !(pend_a_s2 && pend_b_s2);
			out_eof_q    <= eof_s2 && !(pend_a_s2 && pend_b_s2);
		end
	end

	assign pix_out.valid        = out_valid_q;
	assign pix_out.out_sample   = out_sample_q;
	assign pix_out.last_in_run  = out_last_q;
	assign pix_out.end_of_frame = out_eof_q;

endmodule

### rtl/lss_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies; used for the line stores of the sharpening core.
module lss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/lss_sharpen.sv
// Sharpening datapath: signed 3x3 kernel sum over selected window columns,
// sign flip on a negative centre weight, add of the centre sample and clamp.
// Depends on lss_pkg for the window and column-select types.
module lss_sharpen (
	input  lss_pkg::win_t  win,
	input  logic [23:0]    k_top,
	input  logic [23:0]    k_mid,
	input  logic [23:0]    k_bot,
	input  lss_pkg::sel_t  sel,
	output lss_pkg::pix_t  result
);
	import lss_pkg::*;

	logic [2:0][23:0]   krow;
	logic [2:0][1:0]    col;
	logic signed [16:0] prod [3][3];
	logic signed [18:0] row_sum [3];
	logic signed [19:0] sum;
	logic signed [20:0] mid_ext;
	logic signed [20:0] g;

	always_comb begin
		krow = {k_bot, k_mid, k_top};
		col  = {sel.rc, sel.mc, sel.lc};
		for (int a = 0; a < 3; a++) begin
			for (int b = 0; b < 3; b++) begin
				prod[a][b] = $signed(krow[a][b*8 +: 8]) * $signed({1'b0, win[a][col[b]]});
			end
			row_sum[a] = 19'(prod[a][0]) + 19'(prod[a][1]) + 19'(prod[a][2]);
		end
		sum = 20'(row_sum[0]) + 20'(row_sum[1]) + 20'(row_sum[2]);
		if (k_mid[15]) begin
			sum = -sum;
		end
		mid_ext = $signed({13'b0, win[1][sel.mc]});
		g = 21'(sum) + mid_ext;
		if (g < 0) begin
			result = 8'd0;
		end else if (g > 21'sd255) begin
			result = 8'd255;
		end else begin
			result = g[7:0];
		end
	end

endmodule

### rtl/lss_checker.sv
// Port-level checker for the sharpening core and the bind that attaches it.
// Depends on lss_pkg and on the top level laplacian_sharpen_3x3_core.
module lss_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          out_valid,
	input logic          out_ready,
	input lss_pkg::pix_t out_sample,
	input logic          last_in_run,
	input logic          end_of_frame
);
	import lss_pkg::*;

	// A stalled result keeps its transaction unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_sample)
			&& $stable(last_in_run) && $stable(end_of_frame))
		else $error("stalled result changed");

	// The frame ends only on the final result of an item.
	a_eof_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_of_frame |-> last_in_run)
		else $error("end_of_frame without last_in_run");

	// The first of two results of a row end is followed at once by the second.
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_in_run |=> out_valid)
		else $error("second result of a row end did not follow");

	a_reset_idle: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result offered during reset");

endmodule

bind laplacian_sharpen_3x3_core lss_checker u_lss_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (pix_out.valid),
	.out_ready    (pix_out.ready),
	.out_sample   (pix_out.out_sample),
	.last_in_run  (pix_out.last_in_run),
	.end_of_frame (pix_out.end_of_frame)
);
